@@ design/sjs_pkg.sv @@
// ----------------------------------------------------------------------------
// sjs_pkg
// shared types, constants and the double-byte range lookup for the
// shift-jis to utf-8 stream converter
// ----------------------------------------------------------------------------
package sjs_pkg;

	// default depth of the queue between front and back (power of two, >= 2)
	localparam int unsigned QueueDepth = 4;

	localparam int unsigned RangeCount = 20;

	localparam logic [15:0] CpReplacement = 16'hFFFD;
	localparam logic [15:0] KanaCpBase    = 16'hFF61;
	localparam logic [7:0]  KanaFirst     = 8'hA1;
	localparam logic [7:0]  KanaLast      = 8'hDF;
	localparam logic [7:0]  AsciiLimit    = 8'h80;
	localparam logic [7:0]  NulByte       = 8'h00;

	// work item handed from front to back
	typedef struct packed {
		logic        has_cp;  // a code point is to be encoded
		logic [15:0] cp;      // the code point
		logic        term;    // a terminator follows
	} sjs_entry_t;

	localparam logic [15:0] RangeLo [RangeCount] = '{
		16'h8140, 16'h824F, 16'h8260, 16'h8281, 16'h829F,
		16'h8340, 16'h8380, 16'h839F, 16'h83B0, 16'h83BF,
		16'h83D0, 16'h8440, 16'h8446, 16'h8447, 16'h8470,
		16'h8476, 16'h8477, 16'h8480, 16'h8740, 16'h8754
	};

	localparam logic [15:0] RangeHi [RangeCount] = '{
		16'h8142, 16'h8258, 16'h8279, 16'h829A, 16'h82F1,
		16'h837E, 16'h8396, 16'h83AF, 16'h83B6, 16'h83CF,
		16'h83D6, 16'h8445, 16'h8446, 16'h8460, 16'h8475,
		16'h8476, 16'h847E, 16'h8491, 16'h8753, 16'h875D
	};

	localparam logic [15:0] RangeBase [RangeCount] = '{
		16'h3000, 16'hFF10, 16'hFF21, 16'hFF41, 16'h3041,
		16'h30A1, 16'h30E0, 16'h0391, 16'h03A3, 16'h03B1,
		16'h03C3, 16'h0410, 16'h0401, 16'h0416, 16'h0430,
		16'h0451, 16'h0436, 16'h043E, 16'h2460, 16'h2160
	};

	// ranges are disjoint: parallel compares select one offset, one add
	function automatic logic [15:0] sjs_lookup(input logic [15:0] code);
		logic        hit;
		logic [15:0] ofs;
		hit = 1'b0;
		ofs = 16'h0000;
		for (int i = 0; i < RangeCount; i++) begin
			if (code >= RangeLo[i] && code <= RangeHi[i]) begin
				hit = 1'b1;
				ofs = RangeBase[i] - RangeLo[i];
			end
		end
		return hit ? code + ofs : CpReplacement;
	endfunction

endpackage

@@ design/sjs_fifo.sv @@
// ----------------------------------------------------------------------------
// sjs_fifo
// short register queue of work items between front and back
// ----------------------------------------------------------------------------
module sjs_fifo #(
	parameter int unsigned DEPTH = sjs_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sjs_pkg::sjs_entry_t push_data,
	input  logic                pop,
	output sjs_pkg::sjs_entry_t head,
	output logic                not_empty,
	output logic                full
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = PW + 1;

	sjs_pkg::sjs_entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ design/sjs_front.sv @@
// ----------------------------------------------------------------------------
// sjs_front
// accepts shift-jis bytes, pairs lead and trail, resolves code points
// ----------------------------------------------------------------------------
module sjs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                q_push,
	output sjs_pkg::sjs_entry_t q_data
);

	logic [7:0] held_lead_q;
	logic       lead_waiting_q;
	logic       dropping_rest_q;

	logic       accept;
	logic       emit;
	logic [7:0] held_lead_d;
	logic       lead_waiting_d;
	logic       dropping_rest_d;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && emit;

	always_comb begin
		emit            = 1'b0;
		q_data.has_cp   = 1'b0;
		q_data.cp       = sjs_pkg::CpReplacement;
		q_data.term     = s_tlast;
		held_lead_d     = held_lead_q;
		lead_waiting_d  = lead_waiting_q;
		dropping_rest_d = dropping_rest_q;
		priority if (dropping_rest_q) begin
			// swallow the tail after a nul
			if (s_tlast) begin
				dropping_rest_d = 1'b0;
			end
		end else if (s_tdata == sjs_pkg::NulByte) begin
			emit            = 1'b1;
			q_data.has_cp   = lead_waiting_q;
			q_data.term     = 1'b1;
			lead_waiting_d  = 1'b0;
			held_lead_d     = 8'h00;
			dropping_rest_d = !s_tlast;
		end else if (lead_waiting_q) begin
			emit           = 1'b1;
			q_data.has_cp  = 1'b1;
			q_data.cp      = sjs_pkg::sjs_lookup({held_lead_q, s_tdata});
			lead_waiting_d = 1'b0;
			held_lead_d    = 8'h00;
		end else if (s_tdata < sjs_pkg::AsciiLimit) begin
			emit          = 1'b1;
			q_data.has_cp = 1'b1;
			q_data.cp     = {8'h00, s_tdata};
		end else if (s_tdata >= sjs_pkg::KanaFirst && s_tdata <= sjs_pkg::KanaLast) begin
			emit          = 1'b1;
			q_data.has_cp = 1'b1;
			q_data.cp     = sjs_pkg::KanaCpBase + {8'h00, s_tdata - sjs_pkg::KanaFirst};
		end else if (s_tlast) begin
			// lead byte with nothing after it
			emit          = 1'b1;
			q_data.has_cp = 1'b1;
		end else begin
			held_lead_d    = s_tdata;
			lead_waiting_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q     <= 8'h00;
			lead_waiting_q  <= 1'b0;
			dropping_rest_q <= 1'b0;
		end else if (accept) begin
			held_lead_q     <= held_lead_d;
			lead_waiting_q  <= lead_waiting_d;
			dropping_rest_q <= dropping_rest_d;
		end
	end

endmodule

@@ design/sjs_back.sv @@
// ----------------------------------------------------------------------------
// sjs_back
// expands each work item into utf-8 bytes and, when flagged, a terminator, one per cycle unless m_tready stalls
// ----------------------------------------------------------------------------
module sjs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sjs_pkg::sjs_entry_t head,
	input  logic                head_valid,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);

	logic [1:0] idx_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;

	logic [1:0] n_cp;
	logic [2:0] total;
	logic       is_last;
	logic       load;
	logic [7:0] byte_d;
	logic       done_d;

	always_comb begin
		if (!head.has_cp) begin
			n_cp = 2'd0;
		end else if (head.cp < 16'h0080) begin
			n_cp = 2'd1;
		end else if (head.cp < 16'h0800) begin
			n_cp = 2'd2;
		end else begin
			n_cp = 2'd3;
		end
	end

	assign total   = {1'b0, n_cp} + {2'b00, head.term};
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign load    = head_valid && (!m_tvalid_q || m_tready);
	assign q_pop   = load && is_last;

	always_comb begin
		byte_d = 8'h00;
		done_d = 1'b0;
		if (idx_q >= n_cp) begin
			done_d = 1'b1;
		end else begin
			unique case (n_cp)
				2'd1: byte_d = head.cp[7:0];
				2'd2: begin
					if (idx_q == 2'd0) begin
						byte_d = {3'b110, head.cp[10:6]};
					end else begin
						byte_d = {2'b10, head.cp[5:0]};
					end
				end
				2'd3: begin
					if (idx_q == 2'd0) begin
						byte_d = {4'b1110, head.cp[15:12]};
					end else if (idx_q == 2'd1) begin
						byte_d = {2'b10, head.cp[11:6]};
					end else begin
						byte_d = {2'b10, head.cp[5:0]};
					end
				end
				default: byte_d = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= byte_d;
			m_tlast_q <= is_last;
			m_tuser_q <= done_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ design/shift_jis_to_utf8_stream.sv @@
// ----------------------------------------------------------------------------
// shift_jis_to_utf8_stream
// byte stream converter from shift-jis text to utf-8 with string terminators
// ----------------------------------------------------------------------------
//  channel  dir  tdata               tlast          tuser
//  s_*      in   [7:0] in_byte       end_of_string  -
//  m_*      out  [7:0] out_byte      last_of_run    string_done
//
// an input transaction is taken while the queue has room; it yields 0 to 4
// output transactions, one per cycle unless m_tready stalls, from the back
// end's byte serialiser, which sets the sustained rate (3 bytes per kana or
// kanji character, 1 for ascii). an input passes the queue slot, then the
// output register. reset clears lead/drop state, queue pointers and output
// valid. either side may stall freely: the queue decouples them.
// ----------------------------------------------------------------------------
module shift_jis_to_utf8_stream #(
	parameter int unsigned QUEUE_DEPTH = sjs_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser    // [0] string_done
);

	// front to queue
	sjs_pkg::sjs_entry_t push_data;
	logic                push;
	logic                q_full;

	// queue to back
	sjs_pkg::sjs_entry_t head;
	logic                head_valid;
	logic                pop;

	// classifies bytes, holds the lead byte and resolves the code point
	sjs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// short queue of resolved work items
	sjs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (q_full)
	);

	// utf-8 encoder and output register
	sjs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.q_pop      (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

@@ design/sjs_checker.sv @@
// ----------------------------------------------------------------------------
// sjs_checker
// port-level checks on the converter output stream
// ----------------------------------------------------------------------------
module sjs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// no output in the cycle after reset has been seen low
	a_reset_quiet : assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	// a stalled transaction stays offered
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	// a terminator is a nul byte and ends its run
	a_term : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'h00 && m_tlast)
		else $error("terminator malformed");

	// a multi-byte lead is never the last byte of a run
	a_lead_not_last : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:6] == 2'b11 |-> !m_tlast)
		else $error("utf-8 lead byte marked last");

endmodule

bind shift_jis_to_utf8_stream sjs_checker u_sjs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
